FILE: design/rcma_pkg.sv
`timescale 1ns / 1ps

package rcma_pkg;

  localparam int unsigned PIN_W     = 20;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned BIN_W     = 16;
  localparam int unsigned SPAN_W    = 8;
  localparam int unsigned WEIGHT_W  = 16;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned DEMAND_W  = 32;
  localparam int unsigned CFG_W     = 20;
  localparam int unsigned CFG_IDX_W = 3;
  // overlap of one bin in 1/32 units never exceeds a bin width times 32
  localparam int unsigned OVL_W     = BIN_W + 5;
  localparam int unsigned PROD_W    = WEIGHT_W + 2 * OVL_W;
  localparam logic [1:0]  PIN_MIN   = 2'd2;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_COLUMNS = 3'd0,
    REG_GRID_ROWS    = 3'd1,
    REG_CORE_LEFT    = 3'd2,
    REG_CORE_BOTTOM  = 3'd3,
    REG_BIN_WIDTH    = 3'd4,
    REG_BIN_HEIGHT   = 3'd5,
    REG_MIN_SPAN     = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]          action;
    logic [PIN_W-1:0]    pin_x;
    logic [PIN_W-1:0]    pin_y;
    logic                last_pin;
    logic [WEIGHT_W-1:0] net_weight;
    logic [IDX_W-1:0]    read_bin;
  } in_t;

  typedef struct packed {
    logic [DEMAND_W-1:0] horizontal_demand;
    logic [DEMAND_W-1:0] vertical_demand;
    logic                net_counted;
    logic                saturated;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: design/rcma_if.sv
`timescale 1ns / 1ps

interface rcma_in_if import rcma_pkg::*; ();
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rcma_out_if import rcma_pkg::*; ();
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/rcma_div.sv
`timescale 1ns / 1ps

module rcma_div import rcma_pkg::*; #(
  parameter int unsigned NUM_W = 58,
  parameter int unsigned DEN_W = 41
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output div_stat_t        stat_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DEN_W:0]   trial, diff;

  // one quotient bit per cycle, restoring
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
    end else if (busy_q && cnt_q == CW'(1)) begin
      busy_d = 1'b0;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
      cnt_q <= CW'(NUM_W);
    end else if (busy_q) begin
      if (!diff[DEN_W]) begin
        rem_q <= diff[DEN_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[DEN_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

endmodule

FILE: design/rcma_map.sv
`timescale 1ns / 1ps

module rcma_map import rcma_pkg::*; #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  logic [DEMAND_W-1:0] wdata_h_i,
  input  logic [DEMAND_W-1:0] wdata_v_i,
  input  logic                re_i,
  input  logic [AW-1:0]       raddr_i,
  output logic [DEMAND_W-1:0] rdata_h_o,
  output logic [DEMAND_W-1:0] rdata_v_o
);

  logic [DEMAND_W-1:0] hmap_q [DEPTH];
  logic [DEMAND_W-1:0] vmap_q [DEPTH];
  logic [DEMAND_W-1:0] rd_h_q, rd_v_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      hmap_q[waddr_i] <= wdata_h_i;
      vmap_q[waddr_i] <= wdata_v_i;
    end
    if (re_i) begin
      rd_h_q <= hmap_q[raddr_i];
      rd_v_q <= vmap_q[raddr_i];
    end
  end

  assign rdata_h_o = rd_h_q;
  assign rdata_v_o = rd_v_q;

endmodule

FILE: design/rudy_congestion_map_accumulator_top.sv
`timescale 1ns / 1ps
// RUDY congestion map accumulator.
// Input channel in_i carries one beat per action: add pin, clear both maps,
// or read one bin. Output channel out_o returns exactly one result beat for
// every input beat, in order. Registers are written through cfg_we_i /
// cfg_idx_i / cfg_wdata_i; the user must write them only while the block is
// idle, as the block itself does not enforce this. Beats are handled one
// at a time. A clear zeroes one map entry per cycle. A last pin runs a
// set-up with two bin-index divisions, then visits each covered row and
// bin: the shared restoring divider yields one quotient bit per cycle over
// the 58-bit product and runs twice per bin, once per demand.
// After reset both maps are swept to zero, with in_i.ready low and no
// result beat. A finished result waits in an output register; while out_o
// is stalled the block holds its next result and accepts nothing new after
// that.

module rudy_congestion_map_accumulator_top import rcma_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = 64,
  parameter int unsigned MAX_ROWS    = 64,
  parameter int unsigned COORD_BITS  = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  rcma_in_if.sink              in_i,
  rcma_out_if.source           out_o
);

  localparam int unsigned DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CLW   = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned RLW   = $clog2(MAX_ROWS + 1);
  localparam int unsigned CMW   = (CLW > CNT_W) ? CLW : CNT_W;
  localparam int unsigned RMW   = (RLW > CNT_W) ? RLW : CNT_W;
  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned GW    = ((CB + 5 > 32) ? CB + 5 : 32) + 3;
  localparam int unsigned DEN_W = GW + 1;

  typedef enum logic [17:0] {
    S_CLR   = 18'h00001,
    S_IDLE  = 18'h00002,
    S_SET1  = 18'h00004,
    S_SET2  = 18'h00008,
    S_SET3  = 18'h00010,
    S_DIVC  = 18'h00020,
    S_DIVR  = 18'h00040,
    S_ROWI  = 18'h00080,
    S_ROW   = 18'h00100,
    S_COL   = 18'h00200,
    S_MUL1  = 18'h00400,
    S_MUL2  = 18'h00800,
    S_DIVHG = 18'h01000,
    S_DIVH  = 18'h02000,
    S_DIVV  = 18'h04000,
    S_WR    = 18'h08000,
    S_RDCAP = 18'h10000,
    S_DONE  = 18'h20000
  } state_e;

  function automatic logic signed [GW-1:0] ovl(input logic signed [GW-1:0] a0,
                                               input logic signed [GW-1:0] a1,
                                               input logic signed [GW-1:0] b0,
                                               input logic signed [GW-1:0] b1);
    logic signed [GW-1:0] lo, hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a1 < b1) ? a1 : b1;
    return (hi > lo) ? hi - lo : '0;
  endfunction

  state_e state_q, state_d;

  // configuration
  logic [CNT_W-1:0]  grid_columns_q, grid_rows_q;
  logic [PIN_W-1:0]  core_left_q, core_bottom_q;
  logic [BIN_W-1:0]  bin_width_q, bin_height_q;
  logic [SPAN_W-1:0] min_span_q;

  // net under construction
  logic [CB-1:0] box_left_q, box_right_q, box_bottom_q, box_top_q;
  logic [CB-1:0] box_left_d, box_right_d, box_bottom_d, box_top_d;
  logic [1:0]    pins_q, pins_d;
  logic [CB-1:0] px, py;

  logic [AW-1:0] clr_q, clr_d;
  logic          clr_res_q, clr_res_d;
  logic          out_valid_q, out_valid_d;
  out_t          out_q, res_q;
  logic          accept;

  // derived geometry
  logic [CMW-1:0]          gc_w;
  logic [RMW-1:0]          gr_w;
  logic [CLW-1:0]          cols_c;
  logic [RLW-1:0]          rows_c;
  logic [BIN_W-1:0]        bw_c, bh_c;
  logic [OVL_W-1:0]        bw32, bh32;
  logic signed [GW-1:0]    bw32_s, bh32_s, cx0_s, cy0_s;
  logic [SPAN_W+BIN_W-1:0] hwx_p, hwy_p;
  logic signed [GW-1:0]    hwx_s, hwy_s, lx_s, hx_s, ly_s, hy_s;
  logic signed [GW-1:0]    spx_s, spy_s, cenx_s, ceny_s, wx0_s, wx1_s, wy0_s, wy1_s;
  logic [CLW+OVL_W-1:0]    cxw_p, cb0_p;
  logic [RLW+OVL_W-1:0]    cyw_p, rb_p;
  logic [RLW+CLW-1:0]      rc_p;
  logic signed [GW-1:0]    kx1_s, ky1_s, bb_s, bl_s, oy_s, ox_s;

  // working registers of the spread
  logic [WEIGHT_W-1:0]       w_q;
  logic signed [GW-1:0]      bx0_q, bx1_q, by0_q, by1_q, cxw_q, cyw_q, cx1_q, cy1_q;
  logic signed [GW-1:0]      kx0_q, ky0_q, kx1_q, ky1_q, rb_q, cb_q, cb0_q;
  logic [DEN_W-1:0]          xs2_q, ys2_q;
  logic [CLW-1:0]            c0_q, c_q;
  logic [RLW-1:0]            r_q;
  logic [AW-1:0]             ridx_q, idx_q;
  logic [OVL_W-1:0]          ox_q, oy_q;
  logic [WEIGHT_W+OVL_W-1:0] p1_q;
  logic [PROD_W-1:0]         prod_q;
  logic [DEMAND_W-1:0]       inc_h_q, inc_v_q;
  logic                      sat_q, rd_ok_q;
  logic [DEMAND_W:0]         sum_h, sum_v;

  // shared divider and maps
  logic               div_start;
  logic [PROD_W-1:0]  div_num, div_quot;
  logic [DEN_W-1:0]   div_den;
  div_stat_t          div_stat;
  logic               map_we, map_re;
  logic [AW-1:0]      map_waddr, map_raddr;
  logic [DEMAND_W-1:0] map_wh, map_wv, map_rh, map_rv;

  assign accept = in_i.valid && in_i.ready;
  assign px     = CB'(in_i.data.pin_x);
  assign py     = CB'(in_i.data.pin_y);

  assign gc_w   = CMW'(grid_columns_q);
  assign gr_w   = RMW'(grid_rows_q);
  assign cols_c = (grid_columns_q == '0) ? CLW'(1) :
                  (gc_w > CMW'(MAX_COLUMNS)) ? CLW'(MAX_COLUMNS) : CLW'(gc_w);
  assign rows_c = (grid_rows_q == '0) ? RLW'(1) :
                  (gr_w > RMW'(MAX_ROWS)) ? RLW'(MAX_ROWS) : RLW'(gr_w);
  assign bw_c   = (bin_width_q == '0) ? BIN_W'(1) : bin_width_q;
  assign bh_c   = (bin_height_q == '0) ? BIN_W'(1) : bin_height_q;
  assign bw32   = {bw_c, 5'b0};
  assign bh32   = {bh_c, 5'b0};
  assign bw32_s = GW'(bw32);
  assign bh32_s = GW'(bh32);
  assign cx0_s  = GW'(core_left_q) <<< 5;
  assign cy0_s  = GW'(core_bottom_q) <<< 5;

  // widen a short span about its centre, all in 1/32 units
  assign hwx_p  = min_span_q * bw_c;
  assign hwy_p  = min_span_q * bh_c;
  assign hwx_s  = GW'(hwx_p);
  assign hwy_s  = GW'(hwy_p);
  assign lx_s   = GW'(box_left_q);
  assign hx_s   = GW'(box_right_q);
  assign ly_s   = GW'(box_bottom_q);
  assign hy_s   = GW'(box_top_q);
  assign spx_s  = (hx_s - lx_s) <<< 5;
  assign spy_s  = (hy_s - ly_s) <<< 5;
  assign cenx_s = (lx_s + hx_s) <<< 4;
  assign ceny_s = (ly_s + hy_s) <<< 4;
  assign wx0_s  = (spx_s < (hwx_s <<< 1)) ? cenx_s - hwx_s : lx_s <<< 5;
  assign wx1_s  = (spx_s < (hwx_s <<< 1)) ? cenx_s + hwx_s : hx_s <<< 5;
  assign wy0_s  = (spy_s < (hwy_s <<< 1)) ? ceny_s - hwy_s : ly_s <<< 5;
  assign wy1_s  = (spy_s < (hwy_s <<< 1)) ? ceny_s + hwy_s : hy_s <<< 5;

  assign cxw_p  = cols_c * bw32;
  assign cyw_p  = rows_c * bh32;
  assign cb0_p  = c0_q * bw32;
  assign rb_p   = r_q * bh32;
  assign rc_p   = r_q * cols_c;

  assign kx1_s  = (bx1_q < cx1_q) ? bx1_q : cx1_q;
  assign ky1_s  = (by1_q < cy1_q) ? by1_q : cy1_q;
  assign bb_s   = cy0_s + rb_q;
  assign bl_s   = cx0_s + cb_q;
  assign oy_s   = ovl(by0_q, by1_q, bb_s, bb_s + bh32_s);
  assign ox_s   = ovl(bx0_q, bx1_q, bl_s, bl_s + bw32_s);

  assign sum_h  = {1'b0, map_rh} + {1'b0, inc_h_q};
  assign sum_v  = {1'b0, map_rv} + {1'b0, inc_v_q};

  // sequencer
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    clr_res_d    = clr_res_q;
    box_left_d   = box_left_q;
    box_right_d  = box_right_q;
    box_bottom_d = box_bottom_q;
    box_top_d    = box_top_q;
    pins_d       = pins_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    div_start    = 1'b0;
    div_num      = prod_q;
    div_den      = ys2_q;
    map_we       = 1'b0;
    map_waddr    = idx_q;
    map_wh       = sum_h[DEMAND_W] ? '1 : sum_h[DEMAND_W-1:0];
    map_wv       = sum_v[DEMAND_W] ? '1 : sum_v[DEMAND_W-1:0];
    map_re       = 1'b0;
    map_raddr    = idx_q;
    unique case (state_q)
      S_CLR: begin
        map_we    = 1'b1;
        map_waddr = clr_q;
        map_wh    = '0;
        map_wv    = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          clr_d   = '0;
          state_d = clr_res_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        map_raddr = AW'(in_i.data.read_bin);
        if (accept) begin
          state_d = S_DONE;
          unique case (action_e'(in_i.data.action))
            ACT_ADD: begin
              box_left_d   = (px < box_left_q) ? px : box_left_q;
              box_right_d  = (px > box_right_q) ? px : box_right_q;
              box_bottom_d = (py < box_bottom_q) ? py : box_bottom_q;
              box_top_d    = (py > box_top_q) ? py : box_top_q;
              pins_d       = (pins_q < PIN_MIN) ? pins_q + 1'b1 : pins_q;
              if (in_i.data.last_pin) begin
                if (pins_d >= PIN_MIN && in_i.data.net_weight != '0) begin
                  state_d = S_SET1;
                end else begin
                  box_left_d   = '1;
                  box_right_d  = '0;
                  box_bottom_d = '1;
                  box_top_d    = '0;
                  pins_d       = '0;
                end
              end
            end
            ACT_CLEAR: begin
              state_d   = S_CLR;
              clr_res_d = 1'b1;
            end
            ACT_READ: begin
              map_re  = 1'b1;
              state_d = S_RDCAP;
            end
            default: ;
          endcase
        end
      end
      S_SET1: begin
        // box is latched into the working registers here; release it
        box_left_d   = '1;
        box_right_d  = '0;
        box_bottom_d = '1;
        box_top_d    = '0;
        pins_d       = '0;
        state_d      = S_SET2;
      end
      S_SET2: state_d = S_SET3;
      S_SET3: begin
        if (kx1_s <= kx0_q || ky1_s <= ky0_q) begin
          state_d = S_DONE;
        end else begin
          div_start = 1'b1;
          div_num   = PROD_W'($unsigned(kx0_q - cx0_s));
          div_den   = DEN_W'(bw32);
          state_d   = S_DIVC;
        end
      end
      S_DIVC: begin
        if (div_stat.done) begin
          div_start = 1'b1;
          div_num   = PROD_W'($unsigned(ky0_q - cy0_s));
          div_den   = DEN_W'(bh32);
          state_d   = S_DIVR;
        end
      end
      S_DIVR: if (div_stat.done) state_d = S_ROWI;
      S_ROWI: state_d = S_ROW;
      S_ROW: begin
        if (r_q >= rows_c || bb_s >= ky1_q) begin
          state_d = S_DONE;
        end else if (oy_s > '0) begin
          state_d = S_COL;
        end
      end
      S_COL: begin
        if (c_q >= cols_c || bl_s >= kx1_q) begin
          state_d = S_ROW;
        end else if (ox_s > '0) begin
          state_d = S_MUL1;
        end
      end
      S_MUL1: state_d = S_MUL2;
      S_MUL2: begin
        map_re  = 1'b1;
        state_d = S_DIVHG;
      end
      S_DIVHG: begin
        div_start = 1'b1;
        state_d   = S_DIVH;
      end
      S_DIVH: begin
        if (div_stat.done) begin
          div_start = 1'b1;
          div_den   = xs2_q;
          state_d   = S_DIVV;
        end
      end
      S_DIVV: if (div_stat.done) state_d = S_WR;
      S_WR: begin
        map_we  = 1'b1;
        state_d = S_COL;
      end
      S_RDCAP: state_d = S_DONE;
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          clr_res_d   = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLR;
      clr_q          <= '0;
      clr_res_q      <= 1'b0;
      out_valid_q    <= 1'b0;
      box_left_q     <= '1;
      box_right_q    <= '0;
      box_bottom_q   <= '1;
      box_top_q      <= '0;
      pins_q         <= '0;
      grid_columns_q <= CNT_W'(64);
      grid_rows_q    <= CNT_W'(64);
      core_left_q    <= '0;
      core_bottom_q  <= '0;
      bin_width_q    <= BIN_W'(256);
      bin_height_q   <= BIN_W'(256);
      min_span_q     <= SPAN_W'(16);
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      clr_res_q    <= clr_res_d;
      out_valid_q  <= out_valid_d;
      box_left_q   <= box_left_d;
      box_right_q  <= box_right_d;
      box_bottom_q <= box_bottom_d;
      box_top_q    <= box_top_d;
      pins_q       <= pins_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_GRID_COLUMNS: grid_columns_q <= cfg_wdata_i[CNT_W-1:0];
          REG_GRID_ROWS:    grid_rows_q    <= cfg_wdata_i[CNT_W-1:0];
          REG_CORE_LEFT:    core_left_q    <= cfg_wdata_i[PIN_W-1:0];
          REG_CORE_BOTTOM:  core_bottom_q  <= cfg_wdata_i[PIN_W-1:0];
          REG_BIN_WIDTH:    bin_width_q    <= cfg_wdata_i[BIN_W-1:0];
          REG_BIN_HEIGHT:   bin_height_q   <= cfg_wdata_i[BIN_W-1:0];
          REG_MIN_SPAN:     min_span_q     <= cfg_wdata_i[SPAN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath of the spread
  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && (!out_valid_q || out_o.ready)) begin
      out_q <= res_q;
    end
    case (state_q)
      S_IDLE: begin
        res_q   <= '0;
        sat_q   <= 1'b0;
        w_q     <= in_i.data.net_weight;
        rd_ok_q <= 32'(in_i.data.read_bin) < 32'(DEPTH);
      end
      S_SET1: begin
        bx0_q <= wx0_s;
        bx1_q <= wx1_s;
        by0_q <= wy0_s;
        by1_q <= wy1_s;
        cxw_q <= GW'(cxw_p);
        cyw_q <= GW'(cyw_p);
      end
      S_SET2: begin
        cx1_q <= cx0_s + cxw_q;
        cy1_q <= cy0_s + cyw_q;
        kx0_q <= (bx0_q > cx0_s) ? bx0_q : cx0_s;
        ky0_q <= (by0_q > cy0_s) ? by0_q : cy0_s;
      end
      S_SET3: begin
        kx1_q <= kx1_s;
        ky1_q <= ky1_s;
        xs2_q <= {$unsigned(bx1_q - bx0_q), 1'b0};
        ys2_q <= {$unsigned(by1_q - by0_q), 1'b0};
      end
      S_DIVC: begin
        if (div_stat.done) begin
          c0_q <= (div_quot > PROD_W'(cols_c - 1'b1)) ? cols_c - 1'b1 : CLW'(div_quot);
        end
      end
      S_DIVR: begin
        if (div_stat.done) begin
          r_q <= (div_quot > PROD_W'(rows_c - 1'b1)) ? rows_c - 1'b1 : RLW'(div_quot);
        end
      end
      S_ROWI: begin
        rb_q   <= GW'(rb_p);
        ridx_q <= AW'(rc_p);
        cb0_q  <= GW'(cb0_p);
      end
      S_ROW: begin
        if (r_q >= rows_c || bb_s >= ky1_q) begin
          res_q.net_counted <= 1'b1;
          res_q.saturated   <= sat_q;
        end else if (oy_s > '0) begin
          oy_q  <= OVL_W'(oy_s);
          c_q   <= c0_q;
          cb_q  <= cb0_q;
          idx_q <= ridx_q + AW'(c0_q);
        end else begin
          r_q    <= r_q + 1'b1;
          rb_q   <= rb_q + bh32_s;
          ridx_q <= ridx_q + AW'(cols_c);
        end
      end
      S_COL: begin
        if (c_q >= cols_c || bl_s >= kx1_q) begin
          r_q    <= r_q + 1'b1;
          rb_q   <= rb_q + bh32_s;
          ridx_q <= ridx_q + AW'(cols_c);
        end else if (ox_s > '0) begin
          ox_q <= OVL_W'(ox_s);
        end else begin
          c_q   <= c_q + 1'b1;
          cb_q  <= cb_q + bw32_s;
          idx_q <= idx_q + 1'b1;
        end
      end
      S_MUL1: p1_q <= w_q * ox_q;
      S_MUL2: prod_q <= p1_q * oy_q;
      S_DIVH: begin
        if (div_stat.done) begin
          inc_h_q <= (|div_quot[PROD_W-1:DEMAND_W]) ? '1 : div_quot[DEMAND_W-1:0];
        end
      end
      S_DIVV: begin
        if (div_stat.done) begin
          inc_v_q <= (|div_quot[PROD_W-1:DEMAND_W]) ? '1 : div_quot[DEMAND_W-1:0];
        end
      end
      S_WR: begin
        // clip at the top of the map and flag it
        if (sum_h[DEMAND_W] || sum_v[DEMAND_W]) sat_q <= 1'b1;
        c_q   <= c_q + 1'b1;
        cb_q  <= cb_q + bw32_s;
        idx_q <= idx_q + 1'b1;
      end
      S_RDCAP: begin
        if (rd_ok_q) begin
          res_q.horizontal_demand <= map_rh;
          res_q.vertical_demand   <= map_rv;
        end
      end
      default: ;
    endcase
  end

  rcma_div #(
    .NUM_W (PROD_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  rcma_map #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_map (
    .clk_i     (clk_i),
    .we_i      (map_we),
    .waddr_i   (map_waddr),
    .wdata_h_i (map_wh),
    .wdata_v_i (map_wv),
    .re_i      (map_re),
    .raddr_i   (map_raddr),
    .rdata_h_o (map_rh),
    .rdata_v_o (map_rv)
  );

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_accept_drops_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_i.ready)
    else $error("input ready stayed high after an accepted beat");

  a_sat_needs_net: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.saturated |-> out_o.data.net_counted)
    else $error("saturation reported without a spread net");

  a_map_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_we |-> (state_q == S_CLR || state_q == S_WR))
    else $error("map written outside clear sweep or bin update");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

endmodule
